### rtl/core/dwhd_pkg.sv
// dwhd_pkg: shared types, constants and the segment code table for the
// display write height decoder. No dependencies.
`timescale 1ns / 1ps

package dwhd_pkg;

  // display bus addresses of the four digits
  localparam logic [6:0] ADDR_DIGIT1 = 7'h34;
  localparam logic [6:0] ADDR_DIGIT2 = 7'h35;
  localparam logic [6:0] ADDR_DIGIT3 = 7'h36;
  localparam logic [6:0] ADDR_DIGIT4 = 7'h37;

  // frame position counts 0..4 writes
  localparam int unsigned FRAME_LEN = 4;
  localparam int unsigned POS_W     = 3;

  // decoded digit values beyond 0..9
  localparam logic [3:0] CODE_BLANK   = 4'd10;
  localparam logic [3:0] CODE_UNKNOWN = 4'd11;

  localparam int unsigned CM_W = 10;
  localparam int unsigned MM_W = 14;

  // configuration register indexes
  localparam logic CFG_MIN_HEIGHT = 1'b0;
  localparam logic CFG_MAX_HEIGHT = 1'b1;

  localparam logic [CM_W-1:0] MIN_HEIGHT_RST = 10'd40;
  localparam logic [CM_W-1:0] MAX_HEIGHT_RST = 10'd200;

  typedef enum logic [1:0] {
    ST_WAIT    = 2'd0,
    ST_VALID   = 2'd1,
    ST_INVALID = 2'd2
  } dwhd_status_e;

  // frame tracker to decoder: the completed frame's digit bytes
  typedef struct packed {
    logic       complete;
    logic [7:0] hund_seg;
    logic [7:0] tens_seg;
    logic [7:0] ones_seg;
  } dwhd_frame_t;

  // expected address at each frame position: digit 3, 2, 1, 4
  function automatic logic [6:0] expected_addr(input logic [1:0] pos);
    logic [6:0] addr;
    case (pos)
      2'd0:    addr = ADDR_DIGIT3;
      2'd1:    addr = ADDR_DIGIT2;
      2'd2:    addr = ADDR_DIGIT1;
      default: addr = ADDR_DIGIT4;
    endcase
    return addr;
  endfunction

  // seven-segment pattern to digit value
  function automatic logic [3:0] seg_value(input logic [7:0] seg);
    logic [3:0] val;
    case (seg)
      8'h00:   val = CODE_BLANK;
      8'h5F:   val = 4'd0;
      8'h44:   val = 4'd1;
      8'h9E:   val = 4'd2;
      8'hD6:   val = 4'd3;
      8'hC5:   val = 4'd4;
      8'hD3:   val = 4'd5;
      8'hDB:   val = 4'd6;
      8'h46:   val = 4'd7;
      8'hDF:   val = 4'd8;
      8'hD7:   val = 4'd9;
      default: val = CODE_UNKNOWN;
    endcase
    return val;
  endfunction

endpackage

### rtl/core/dwhd_frame.sv
// dwhd_frame: frame order tracker and digit store for the height decoder.
// Depends on dwhd_pkg.
`timescale 1ns / 1ps

module dwhd_frame (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_en_i,
  input  logic [6:0]           addr_i,
  input  logic [7:0]           seg_i,
  output dwhd_pkg::dwhd_frame_t frame_o
);

  logic [dwhd_pkg::POS_W-1:0] pos_q, pos_d;
  logic [7:0]                 digit_q [3];
  logic [7:0]                 digit_d [3];

  logic                       in_range;
  logic                       restart;
  logic [dwhd_pkg::POS_W-1:0] pos_eff;
  logic                       in_order;

  assign in_range = (addr_i >= dwhd_pkg::ADDR_DIGIT1) && (addr_i <= dwhd_pkg::ADDR_DIGIT4);
  assign restart  = (addr_i == dwhd_pkg::ADDR_DIGIT3);
  // a digit 3 write drops the frame before the order check
  assign pos_eff  = restart ? '0 : pos_q;
  assign in_order = (pos_eff < dwhd_pkg::POS_W'(dwhd_pkg::FRAME_LEN))
                    && (addr_i == dwhd_pkg::expected_addr(pos_eff[1:0]));

  always_comb begin
    pos_d   = pos_q;
    digit_d = digit_q;
    if (req_en_i && in_range) begin
      if (restart || !in_order) begin
        pos_d   = '0;
        digit_d = '{default: '0};
      end
      if (in_order) begin
        pos_d = pos_eff + 1'b1;
        if (addr_i[1:0] != 2'd3) begin
          digit_d[addr_i[1:0]] = seg_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      digit_q <= '{default: '0};
    end else begin
      pos_q   <= pos_d;
      digit_q <= digit_d;
    end
  end

  // the digit 4 write closes the frame; digits 1..3 are already stored
  assign frame_o.complete = in_range && in_order
                            && (pos_eff == dwhd_pkg::POS_W'(dwhd_pkg::FRAME_LEN - 1));
  assign frame_o.hund_seg = digit_q[0];
  assign frame_o.tens_seg = digit_q[1];
  assign frame_o.ones_seg = digit_q[2];

endmodule

### rtl/core/dwhd_decode.sv
// dwhd_decode: segment decode, height assembly and limit check.
// Depends on dwhd_pkg.
`timescale 1ns / 1ps

module dwhd_decode (
  input  dwhd_pkg::dwhd_frame_t          frame_i,
  input  logic [dwhd_pkg::CM_W-1:0]      min_cm_i,
  input  logic [dwhd_pkg::CM_W-1:0]      max_cm_i,
  output dwhd_pkg::dwhd_status_e         status_o,
  output logic [dwhd_pkg::MM_W-1:0]      height_mm_o
);

  logic [3:0]                hund, tens, ones;
  logic                      bad_digit;
  logic [dwhd_pkg::CM_W-1:0] hund_cm, cm;

  assign hund = dwhd_pkg::seg_value(frame_i.hund_seg);
  assign tens = dwhd_pkg::seg_value(frame_i.tens_seg);
  assign ones = dwhd_pkg::seg_value(frame_i.ones_seg);

  // tens and ones must be real digits; hundreds may be blank
  assign bad_digit = (hund == dwhd_pkg::CODE_UNKNOWN) || (tens > 4'd9) || (ones > 4'd9);

  assign hund_cm = (hund == dwhd_pkg::CODE_BLANK) ? '0
                   : dwhd_pkg::CM_W'(hund) * dwhd_pkg::CM_W'(100);
  assign cm = hund_cm + dwhd_pkg::CM_W'(tens) * dwhd_pkg::CM_W'(10)
              + dwhd_pkg::CM_W'(ones);

  always_comb begin
    status_o    = dwhd_pkg::ST_WAIT;
    height_mm_o = '0;
    if (frame_i.complete) begin
      if (bad_digit || (cm < min_cm_i) || (cm > max_cm_i)) begin
        status_o = dwhd_pkg::ST_INVALID;
      end else begin
        status_o    = dwhd_pkg::ST_VALID;
        height_mm_o = dwhd_pkg::MM_W'(cm) * dwhd_pkg::MM_W'(10);
      end
    end
  end

endmodule

### rtl/core/display_write_height_decoder.sv
// display_write_height_decoder: top level with request register, frame
// tracker, decoder and result register. Depends on dwhd_pkg, dwhd_frame, dwhd_decode.
`timescale 1ns / 1ps

// channel   | dir | tdata fields (lsb first)                         | width
// s_axis    | in  | digit_address[6:0], segment_byte[14:7], pad[15] | 16
// m_axis    | out | status[1:0], height_mm[15:2]                     | 16
// cfg       | in  | cfg_idx_i selects min (0) or max (1) height, cm  | 10
//
// one result per request; a request passes through the request register
// and then the result register, and one request is taken every cycle
// when m_axis_tready stays high.
// the frame tracker state updates as a request moves into the result
// register; a stalled result register holds the request register, which
// still takes a new request the cycle the result is taken.
// reset clears valids, frame position, digit store and sets limits 40/200 cm.

module display_write_height_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // digit_address[6:0], segment_byte[14:7]

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // status[1:0], height_mm[15:2]

  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [9:0]  cfg_wdata_i
);

  // request register
  logic       req_valid_q, req_valid_d;
  logic [6:0] req_addr_q;
  logic [7:0] req_seg_q;

  // result register
  logic                          rsp_valid_q, rsp_valid_d;
  dwhd_pkg::dwhd_status_e        rsp_status_q;
  logic [dwhd_pkg::MM_W-1:0]     rsp_height_q;

  // configuration
  logic [dwhd_pkg::CM_W-1:0] min_cm_q, max_cm_q;

  logic                          advance;
  logic                          s_accept;
  dwhd_pkg::dwhd_frame_t         frame;
  dwhd_pkg::dwhd_status_e        dec_status;
  logic [dwhd_pkg::MM_W-1:0]     dec_height;

  // request moves on when the result register is free or being emptied
  assign advance       = req_valid_q && (!rsp_valid_q || m_axis_tready);
  assign s_axis_tready = !req_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign req_valid_d = s_accept || (req_valid_q && !advance);
  assign rsp_valid_d = advance || (rsp_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      req_addr_q <= s_axis_tdata[6:0];
      req_seg_q  <= s_axis_tdata[14:7];
    end
    if (advance) begin
      rsp_status_q <= dec_status;
      rsp_height_q <= dec_height;
    end
  end

  // height limits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_cm_q <= dwhd_pkg::MIN_HEIGHT_RST;
      max_cm_q <= dwhd_pkg::MAX_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dwhd_pkg::CFG_MIN_HEIGHT: min_cm_q <= cfg_wdata_i;
        dwhd_pkg::CFG_MAX_HEIGHT: max_cm_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  dwhd_frame u_frame (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_en_i(advance),
    .addr_i  (req_addr_q),
    .seg_i   (req_seg_q),
    .frame_o (frame)
  );

  dwhd_decode u_decode (
    .frame_i    (frame),
    .min_cm_i   (min_cm_q),
    .max_cm_i   (max_cm_q),
    .status_o   (dec_status),
    .height_mm_o(dec_height)
  );

  assign m_axis_tvalid = rsp_valid_q;
  assign m_axis_tdata  = {rsp_height_q, rsp_status_q};

endmodule
